[sv/dfq_pkg.sv]
// shared types, widths and codes for the duplicate-rejecting queue
package dfq_pkg;

    localparam int CATALOGUE_SIZE_DEF = 16;

    localparam int CMD_W    = 2;
    localparam int NUM_W    = 5;
    localparam int DUR_W    = 16;
    localparam int POS_W    = 5;
    localparam int STATUS_W = 3;
    localparam int COUNT_W  = 5;
    localparam int TOTAL_W  = 20;

    localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

    typedef enum logic [CMD_W-1:0] {
        CMD_APPEND = 2'd0,
        CMD_POP    = 2'd1,
        CMD_DELETE = 2'd2,
        CMD_CLEAR  = 2'd3
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 3'd0,
        ST_INVALID   = 3'd1,
        ST_DUPLICATE = 3'd2,
        ST_EMPTY     = 3'd3,
        ST_RANGE     = 3'd4
    } status_t;

    typedef struct packed {
        cmd_t             cmd;
        logic [NUM_W-1:0] song_number;
        logic [DUR_W-1:0] song_duration;
        logic [POS_W-1:0] position;
    } request_t;

    typedef struct packed {
        status_t            status;
        logic [NUM_W-1:0]   item_number;
        logic [DUR_W-1:0]   item_duration;
        logic [COUNT_W-1:0] queue_count;
        logic [TOTAL_W-1:0] total_seconds;
    } result_t;

endpackage

[sv/dedup_fifo_with_positional_remove.sv]
// top level of the duplicate-rejecting queue with delete by position
//
// input channel: in_valid / in_stall carry one command transaction
//   (cmd, song_number, song_duration, position); append, pop head,
//   delete at a 1-based position, or clear all
// output channel: out_valid / out_stall carry one result transaction per
//   command (status, item_number, item_duration, queue_count, total_seconds)
// throughput: one transaction per cycle unless the receiver stalls; every
//   command is decoded and applied to the queue combinationally between the
//   input and result registers, deletes shift all later entries up in parallel
// path: the input register holds an accepted command, and the result register
//   then holds its result and offers it to the receiver
// reset: queue count, presence map and running total clear at once; the
//   entry storage is not cleared and is only read below the count
// receiver stall: the result register holds its transaction; the command
//   waiting in the input register stalls, and in_stall rises once that
//   register is occupied as well, so nothing is lost or repeated
module dedup_fifo_with_positional_remove
    import dfq_pkg::*;
#(
    parameter int CATALOGUE_SIZE = CATALOGUE_SIZE_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [CMD_W-1:0]    cmd,
    input  logic [NUM_W-1:0]    song_number,
    input  logic [DUR_W-1:0]    song_duration,
    input  logic [POS_W-1:0]    position,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [STATUS_W-1:0] status,
    output logic [NUM_W-1:0]    item_number,
    output logic [DUR_W-1:0]    item_duration,
    output logic [COUNT_W-1:0]  queue_count,
    output logic [TOTAL_W-1:0]  total_seconds
);

    // input register
    logic     in_valid_reg;
    logic     in_valid_next;
    request_t req_reg;

    logic     step;
    logic     free;
    result_t  res;
    result_t  out_res;

    // a command moves on whenever the result register can take its result
    assign step     = in_valid_reg && free;
    assign in_stall = in_valid_reg && !free;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (in_valid && !in_stall)
        begin
            in_valid_next = 1'b1;
        end
        else if (step)
        begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            req_reg.cmd           <= cmd_t'(cmd);
            req_reg.song_number   <= song_number;
            req_reg.song_duration <= song_duration;
            req_reg.position      <= position;
        end
    end

    // queue state and command decode
    dfq_core #(
        .CATALOGUE_SIZE (CATALOGUE_SIZE)
    ) u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (step),
        .req   (req_reg),
        .res   (res)
    );

    // result register
    dfq_out_reg u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (step),
        .res       (res),
        .out_stall (out_stall),
        .free      (free),
        .out_valid (out_valid),
        .out_res   (out_res)
    );

    assign status        = out_res.status;
    assign item_number   = out_res.item_number;
    assign item_duration = out_res.item_duration;
    assign queue_count   = out_res.queue_count;
    assign total_seconds = out_res.total_seconds;

endmodule

[sv/dfq_core.sv]
// queue storage, presence map, running total and combinational command logic
module dfq_core
    import dfq_pkg::*;
#(
    parameter int CATALOGUE_SIZE = CATALOGUE_SIZE_DEF
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     step,
    input  request_t req,
    output result_t  res
);

    localparam int CNT_W  = $clog2(CATALOGUE_SIZE + 1);
    localparam int SUM_W  = DUR_W + CNT_W;
    localparam int WIDE_W = (SUM_W > TOTAL_W) ? SUM_W : TOTAL_W + 1;

    logic [NUM_W-1:0]          num_reg  [CATALOGUE_SIZE];
    logic [NUM_W-1:0]          num_next [CATALOGUE_SIZE];
    logic [DUR_W-1:0]          dur_reg  [CATALOGUE_SIZE];
    logic [DUR_W-1:0]          dur_next [CATALOGUE_SIZE];
    logic [CATALOGUE_SIZE-1:0] map_reg;
    logic [CATALOGUE_SIZE-1:0] map_next;
    logic [CNT_W-1:0]          count_reg;
    logic [CNT_W-1:0]          count_next;
    logic [SUM_W-1:0]          sum_reg;
    logic [SUM_W-1:0]          sum_next;

    logic [CATALOGUE_SIZE-1:0] num_onehot;
    logic [CATALOGUE_SIZE-1:0] take_onehot;
    logic [POS_W-1:0]          take_idx;
    logic [NUM_W-1:0]          take_num;
    logic [DUR_W-1:0]          take_dur;
    logic                      num_ok;
    logic                      dup;
    logic                      full;
    logic                      pos_ok;
    logic [WIDE_W-1:0]         sum_wide;

    // presence decode and selection of the entry being taken out
    always_comb
    begin
        num_ok   = (req.song_number != '0) && (req.song_number <= NUM_W'(CATALOGUE_SIZE));
        full     = (count_reg == CNT_W'(CATALOGUE_SIZE));
        pos_ok   = (req.position != '0) && (req.position <= POS_W'(count_reg));
        take_idx = (req.cmd == CMD_POP) ? '0 : req.position - POS_W'(1);
        take_num = '0;
        take_dur = '0;
        for (int i = 0; i < CATALOGUE_SIZE; i++)
        begin
            num_onehot[i] = (req.song_number == NUM_W'(i + 1));
            if (take_idx == POS_W'(i))
            begin
                take_num = take_num | num_reg[i];
                take_dur = take_dur | dur_reg[i];
            end
        end
        for (int j = 0; j < CATALOGUE_SIZE; j++)
        begin
            take_onehot[j] = (take_num == NUM_W'(j + 1));
        end
        dup = |(map_reg & num_onehot);
    end

    always_comb
    begin
        num_next          = num_reg;
        dur_next          = dur_reg;
        map_next          = map_reg;
        count_next        = count_reg;
        sum_next          = sum_reg;
        res.status        = ST_OK;
        res.item_number   = '0;
        res.item_duration = '0;
        case (req.cmd)
            CMD_APPEND:
            begin
                if (!num_ok)
                begin
                    res.status = ST_INVALID;
                end
                else if (dup)
                begin
                    res.status = ST_DUPLICATE;
                end
                else if (full)
                begin
                    res.status = ST_INVALID;
                end
                else
                begin
                    for (int i = 0; i < CATALOGUE_SIZE; i++)
                    begin
                        if (count_reg == CNT_W'(i))
                        begin
                            num_next[i] = req.song_number;
                            dur_next[i] = req.song_duration;
                        end
                    end
                    count_next        = count_reg + CNT_W'(1);
                    map_next          = map_reg | num_onehot;
                    sum_next          = sum_reg + SUM_W'(req.song_duration);
                    res.item_number   = req.song_number;
                    res.item_duration = req.song_duration;
                end
            end
            CMD_POP, CMD_DELETE:
            begin
                if (count_reg == '0)
                begin
                    res.status = ST_EMPTY;
                end
                else if ((req.cmd == CMD_DELETE) && !pos_ok)
                begin
                    res.status = ST_RANGE;
                end
                else
                begin
                    // later entries close the gap
                    for (int i = 0; i < CATALOGUE_SIZE - 1; i++)
                    begin
                        if (POS_W'(i) >= take_idx)
                        begin
                            num_next[i] = num_reg[i + 1];
                            dur_next[i] = dur_reg[i + 1];
                        end
                    end
                    count_next        = count_reg - CNT_W'(1);
                    map_next          = map_reg & ~take_onehot;
                    sum_next          = sum_reg - SUM_W'(take_dur);
                    res.item_number   = take_num;
                    res.item_duration = take_dur;
                end
            end
            CMD_CLEAR:
            begin
                count_next = '0;
                map_next   = '0;
                sum_next   = '0;
            end
            default:
            begin
                res.status = ST_OK;
            end
        endcase
        sum_wide          = WIDE_W'(sum_next);
        res.queue_count   = COUNT_W'(count_next);
        res.total_seconds = (sum_wide > WIDE_W'(TOTAL_MAX)) ? TOTAL_MAX
                                                            : sum_wide[TOTAL_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            map_reg   <= '0;
            count_reg <= '0;
            sum_reg   <= '0;
        end
        else if (step)
        begin
            map_reg   <= map_next;
            count_reg <= count_next;
            sum_reg   <= sum_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            num_reg <= num_next;
            dur_reg <= dur_next;
        end
    end

endmodule

[sv/dfq_out_reg.sv]
// result register with stall handling towards the receiver
module dfq_out_reg
    import dfq_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    load,
    input  result_t res,
    input  logic    out_stall,
    output logic    free,
    output logic    out_valid,
    output result_t out_res
);

    logic    valid_reg;
    logic    valid_next;
    result_t res_reg;

    assign free      = !valid_reg || !out_stall;
    assign out_valid = valid_reg;
    assign out_res   = res_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (valid_reg && !out_stall)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= res;
        end
    end

endmodule
